// ===== design/cbc_pkg.sv =====
// Shared types and constants for the cartridge bank controller.
package cbc_pkg;

    typedef enum logic [2:0] {
        OUT_ROM_READ  = 3'd0,
        OUT_RAM_READ  = 3'd1,
        OUT_RAM_WRITE = 3'd2,
        OUT_OPEN_BUS  = 3'd3,
        OUT_NONE      = 3'd4
    } t_outcome;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 22;
    localparam int ADDR_W       = 16;
    localparam int PHYS_W       = 21;
    localparam int BYTE_W       = 8;
    localparam int ROM_BANK_W   = 7;
    localparam int RAM_BANK_W   = 2;
    localparam int RAM_COUNT_W  = 5;
    localparam int ROM_SIZE_W   = 22;
    localparam int RAM_OFF_W    = 15;
    localparam int RAM_CMP_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CART_KIND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE   = 2'd3;

    localparam int DEFAULT_RAM_BYTES = 32768;

    localparam logic [ADDR_W-1:0] ADDR_RAM_EN_END   = 16'h1FFF;
    localparam logic [ADDR_W-1:0] ADDR_ROM0_END     = 16'h3FFF;
    localparam logic [ADDR_W-1:0] ADDR_RAM_BANK_END = 16'h5FFF;
    localparam logic [ADDR_W-1:0] ADDR_ROMX_END     = 16'h7FFF;
    localparam logic [ADDR_W-1:0] ADDR_EXT_RAM      = 16'hA000;
    localparam logic [ADDR_W-1:0] ADDR_EXT_RAM_END  = 16'hBFFF;

    localparam logic [3:0] RAM_EN_KEY = 4'hA;

endpackage

// ===== design/cartridge_bank_controller_unit.sv =====
// Cartridge bank controller: bus access translation and bank register updates.
//
// Each bus access transfer yields exactly one result: a ROM byte address, an
// external RAM byte address (read or write, with the byte to store), an open
// bus read, or no memory effect. An accepted access is held in an input
// register, is decoded against the bank registers, and lands in the result
// register. One access can be taken every cycle unless i_ready stalls the result.
// Bank registers change at the same edge that the access moves into the
// result register, so each access sees every earlier write. The configuration
// port (kind, ROM bank mask, RAM bank count, ROM size) must be written only while
// no access is in flight; the block itself does not enforce this.
module cartridge_bank_controller_unit #(
    parameter int RAM_BYTES = cbc_pkg::DEFAULT_RAM_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_write,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_kind,
    input  logic [cbc_pkg::ADDR_W-1:0]       i_bus_address,
    input  logic [cbc_pkg::BYTE_W-1:0]       i_write_value,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [2:0]                       o_outcome,
    output logic [cbc_pkg::PHYS_W-1:0]       o_physical_address,
    output logic [cbc_pkg::BYTE_W-1:0]       o_ram_write_value
);
    import cbc_pkg::*;

    localparam logic [RAM_CMP_W-1:0] RAM_LIMIT = RAM_CMP_W'(RAM_BYTES);

    // configuration
    logic                   r_cart_kind;
    logic [ROM_BANK_W-1:0]  r_bank_mask;
    logic [RAM_COUNT_W-1:0] r_ram_count;
    logic [ROM_SIZE_W-1:0]  r_rom_bytes;

    // bank state
    logic                   r_ram_en,   n_ram_en;
    logic [ROM_BANK_W-1:0]  r_rom_bank, n_rom_bank;
    logic [RAM_BANK_W-1:0]  r_ram_bank, n_ram_bank;
    logic                   r_mode,     n_mode;

    // input stage
    logic                   r_in_valid;
    logic                   r_in_kind;
    logic [ADDR_W-1:0]      r_in_addr;
    logic [BYTE_W-1:0]      r_in_val;

    // result stage
    logic                   r_out_valid;
    t_outcome               r_outcome,  n_outcome;
    logic [PHYS_W-1:0]      r_phys,     n_phys;
    logic [BYTE_W-1:0]      r_wval,     n_wval;

    logic                   adv;
    logic [PHYS_W-1:0]      flat_phys, banked_phys, rom_phys;
    logic [RAM_BANK_W-1:0]  eff_ram_bank;
    logic [RAM_OFF_W-1:0]   ram_off;
    logic                   ram_ok;
    logic                   rom_sel;
    logic [ROM_BANK_W-1:0]  bank_lo_wr;

    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    assign flat_phys   = PHYS_W'(r_in_addr);
    assign banked_phys = {r_rom_bank & r_bank_mask, r_in_addr[13:0]};

    always_comb begin
        eff_ram_bank = '0;
        if (r_mode && ({{(RAM_COUNT_W-RAM_BANK_W){1'b0}}, r_ram_bank} < r_ram_count)) begin
            eff_ram_bank = r_ram_bank;
        end
    end
    assign ram_off = {eff_ram_bank, r_in_addr[12:0]};
    // RAM access is possible: window hit, enabled, present and inside the RAM
    assign ram_ok  = (r_in_addr >= ADDR_EXT_RAM) && (r_in_addr <= ADDR_EXT_RAM_END)
                     && r_ram_en && (r_ram_count != '0)
                     && ({1'b0, ram_off} < RAM_LIMIT);

    // ROM bank low write: zero value selects bank one
    always_comb begin
        bank_lo_wr = {r_rom_bank[6:5], r_in_val[4:0]};
        if (r_in_val == '0) begin
            bank_lo_wr[0] = 1'b1;
        end
    end

    always_comb begin
        n_outcome  = OUT_NONE;
        n_phys     = '0;
        n_wval     = '0;
        n_ram_en   = r_ram_en;
        n_rom_bank = r_rom_bank;
        n_ram_bank = r_ram_bank;
        n_mode     = r_mode;
        rom_sel    = 1'b0;
        rom_phys   = flat_phys;

        if (!r_cart_kind) begin
            rom_sel = !r_in_kind;
        end else if (!r_in_kind) begin
            priority if (r_in_addr <= ADDR_ROM0_END) begin
                rom_sel = 1'b1;
            end else if (r_in_addr <= ADDR_ROMX_END) begin
                rom_sel  = 1'b1;
                rom_phys = banked_phys;
            end else if (r_in_addr <= ADDR_EXT_RAM_END) begin
                if (ram_ok) begin
                    n_outcome = OUT_RAM_READ;
                    n_phys    = PHYS_W'(ram_off);
                end else begin
                    n_outcome = OUT_OPEN_BUS;
                end
            end else begin
                rom_sel = 1'b1;
            end
        end else begin
            priority if (r_in_addr <= ADDR_RAM_EN_END) begin
                n_ram_en = (r_in_val[3:0] == RAM_EN_KEY);
            end else if (r_in_addr <= ADDR_ROM0_END) begin
                n_rom_bank = bank_lo_wr & r_bank_mask;
            end else if (r_in_addr <= ADDR_RAM_BANK_END) begin
                if (r_mode) begin
                    n_ram_bank = r_in_val[1:0];
                end else begin
                    n_rom_bank = {r_in_val[1:0], r_rom_bank[4:0]} & r_bank_mask;
                end
            end else if (r_in_addr <= ADDR_ROMX_END) begin
                n_mode = r_in_val[0];
            end else if (ram_ok) begin
                n_outcome = OUT_RAM_WRITE;
                n_phys    = PHYS_W'(ram_off);
                n_wval    = r_in_val;
            end else begin
                n_outcome = OUT_NONE;
            end
        end

        // size check shared by every ROM read path
        if (rom_sel) begin
            if ({1'b0, rom_phys} >= r_rom_bytes) begin
                n_outcome = OUT_OPEN_BUS;
            end else begin
                n_outcome = OUT_ROM_READ;
                n_phys    = rom_phys;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cart_kind <= 1'b1;
            r_bank_mask <= 7'd127;
            r_ram_count <= '0;
            r_rom_bytes <= ROM_SIZE_W'(32768);
            r_ram_en    <= 1'b0;
            r_rom_bank  <= '0;
            r_ram_bank  <= '0;
            r_mode      <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                unique case (i_cfg_index)
                    CFG_CART_KIND: r_cart_kind <= i_cfg_data[0];
                    CFG_BANK_MASK: r_bank_mask <= i_cfg_data[ROM_BANK_W-1:0];
                    CFG_RAM_COUNT: r_ram_count <= i_cfg_data[RAM_COUNT_W-1:0];
                    CFG_ROM_SIZE:  r_rom_bytes <= i_cfg_data[ROM_SIZE_W-1:0];
                    default:       r_cart_kind <= r_cart_kind;
                endcase
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_ram_en    <= n_ram_en;
                r_rom_bank  <= n_rom_bank;
                r_ram_bank  <= n_ram_bank;
                r_mode      <= n_mode;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_kind <= i_kind;
            r_in_addr <= i_bus_address;
            r_in_val  <= i_write_value;
        end
        if (adv) begin
            r_outcome <= n_outcome;
            r_phys    <= n_phys;
            r_wval    <= n_wval;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_outcome          = r_outcome;
    assign o_physical_address = r_phys;
    assign o_ram_write_value  = r_wval;

endmodule
